// ===== src/poisson_stencil_sweep_macros.svh =====
// Assertion macros for the five-point stencil sweep.
// Used by the top level; expects clk and rst in the scope of each use.
`ifndef POISSON_STENCIL_SWEEP_MACROS_SVH
`define POISSON_STENCIL_SWEEP_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define SPS_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("stencil sweep: invariant violated");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define SPS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stencil sweep: implication violated");

`endif

// ===== src/sps_pkg.sv =====
// Shared constants, types and helper functions of the stencil sweep.
// No dependencies; every module file imports it.
package sps_pkg;

  localparam int MAX_ROW_WIDTH = 1024;
  localparam int ADDR_BITS = $clog2(MAX_ROW_WIDTH);
  localparam int WIDTH_BITS = ADDR_BITS + 1;
  localparam int VALUE_BITS = 32;
  localparam int H_BITS = 32;
  localparam int COL_BITS = 10;
  localparam int ROW_BITS = 16;
  localparam int CHANGE_BITS = 31;
  localparam int SUM_BITS = VALUE_BITS + 2;
  localparam int PROD_BITS = VALUE_BITS + H_BITS;
  localparam int CFG_BITS = 32;

  localparam logic [1:0] REG_INTERIOR_COLUMNS = 2'd0;
  localparam logic [1:0] REG_START_ROW = 2'd1;
  localparam logic [1:0] REG_END_ROW = 2'd2;
  localparam logic [1:0] REG_H_SQUARED = 2'd3;

  localparam logic [COL_BITS-1:0] COLS_RESET = COL_BITS'(1022);
  localparam logic [ROW_BITS-1:0] START_ROW_RESET = ROW_BITS'(1);
  localparam logic [ROW_BITS-1:0] END_ROW_RESET = ROW_BITS'(1);
  localparam logic [COL_BITS-1:0] COLS_LIMIT = COL_BITS'(MAX_ROW_WIDTH - 2);
  localparam logic [ROW_BITS-1:0] END_ROW_LIMIT = ROW_BITS'(65534);

  typedef struct packed {
    logic [COL_BITS-1:0]   cols;
    logic [WIDTH_BITS-1:0] width;
    logic [ROW_BITS-1:0]   start_row;
    logic [ROW_BITS-1:0]   end_row;
    logic [H_BITS-1:0]     h_squared;
  } cfg_t;

  typedef struct packed {
    logic                res;
    logic                clr;
    logic                last;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
  } tag_t;

  typedef struct packed {
    tag_t                         tag;
    logic signed [SUM_BITS-1:0]   sum;
    logic signed [VALUE_BITS-1:0] rhs;
    logic signed [VALUE_BITS-1:0] mid;
  } stage1_t;

  typedef struct packed {
    tag_t                         tag;
    logic signed [VALUE_BITS-1:0] nv;
    logic signed [VALUE_BITS-1:0] mid;
  } stage3_t;

  function automatic cfg_t make_cfg(input logic [COL_BITS-1:0] cols_raw,
                                    input logic [ROW_BITS-1:0] first_raw,
                                    input logic [ROW_BITS-1:0] last_raw,
                                    input logic [H_BITS-1:0] h_raw);
    cfg_t c;
    if (cols_raw == '0) begin
      c.cols = COL_BITS'(1);
    end else if (cols_raw > COLS_LIMIT) begin
      c.cols = COLS_LIMIT;
    end else begin
      c.cols = cols_raw;
    end
    c.width = WIDTH_BITS'(c.cols) + WIDTH_BITS'(2);
    c.start_row = (first_raw == '0) ? ROW_BITS'(1) : first_raw;
    c.end_row = (last_raw > END_ROW_LIMIT) ? END_ROW_LIMIT : last_raw;
    c.h_squared = h_raw;
    return c;
  endfunction

  function automatic logic [ADDR_BITS-1:0] clamp_col(input logic [ADDR_BITS-1:0] pos,
                                                     input logic [WIDTH_BITS-1:0] width);
    logic [WIDTH_BITS-1:0] last_col;
    last_col = width - WIDTH_BITS'(1);
    if (WIDTH_BITS'(pos) >= width) begin
      return last_col[ADDR_BITS-1:0];
    end
    return pos;
  endfunction

endpackage

// ===== src/sps_line_buffer.sv =====
// Raster position tracking, the three line stores and the stencil window.
// Registers the neighbour sum and tags of each cell that completes. Uses sps_pkg.
module sps_line_buffer
  import sps_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  cfg_t                         cfg,
  input  cfg_t                         cfg_next,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] old_value,
  input  logic signed [VALUE_BITS-1:0] rhs_value,
  output logic                         s1_valid,
  output stage1_t                      s1,
  input  logic                         s1_ready
);

  logic [VALUE_BITS-1:0] above_mem [MAX_ROW_WIDTH];
  logic [VALUE_BITS-1:0] middle_mem [MAX_ROW_WIDTH];
  logic [VALUE_BITS-1:0] rhs_mem [MAX_ROW_WIDTH];

  logic [ADDR_BITS-1:0] col_pos;
  logic [ROW_BITS-1:0]  row_pos;
  logic [ADDR_BITS-1:0] col_pos_next;
  logic [ROW_BITS-1:0]  row_pos_next;
  logic [ADDR_BITS-1:0] col;
  logic [ADDR_BITS-1:0] col_adv;
  logic [ROW_BITS-1:0]  row_adv;
  logic [WIDTH_BITS-1:0] col_inc;
  logic [ROW_BITS:0]    row_inc;
  logic [ROW_BITS-1:0]  row_m1;
  logic [ADDR_BITS-1:0] rd_col;
  logic [ADDR_BITS-1:0] rd_col_right;

  logic signed [VALUE_BITS-1:0] up_rd;
  logic signed [VALUE_BITS-1:0] mid_rd;
  logic signed [VALUE_BITS-1:0] right_rd;
  logic signed [VALUE_BITS-1:0] rhs_rd;
  logic signed [VALUE_BITS-1:0] right;
  logic signed [VALUE_BITS-1:0] window_center;
  logic signed [SUM_BITS-1:0]   sum;

  logic    ready;
  logic    accept;
  logic    res;
  logic    clr;
  stage1_t s1_next;

  assign ready = !s1_valid || s1_ready;
  assign accept = in_valid && ready && !rst;
  assign in_stall = rst || !ready;

  always_comb begin
    col = clamp_col(col_pos, cfg.width);
    col_inc = WIDTH_BITS'(col) + WIDTH_BITS'(1);
    row_inc = (ROW_BITS+1)'(row_pos) + (ROW_BITS+1)'(1);
    if (col_inc >= cfg.width) begin
      col_adv = '0;
      if (row_inc > (ROW_BITS+1)'(cfg.end_row) + (ROW_BITS+1)'(1)) begin
        row_adv = '0;
      end else begin
        row_adv = row_inc[ROW_BITS-1:0];
      end
    end else begin
      col_adv = col_inc[ADDR_BITS-1:0];
      row_adv = row_pos;
    end
    col_pos_next = accept ? col_adv : col_pos;
    row_pos_next = accept ? row_adv : row_pos;
    // Reads are issued for the position of the next beat, so the window is
    // ready when that beat arrives.
    rd_col = clamp_col(col_pos_next, cfg_next.width);
    rd_col_right = rd_col + ADDR_BITS'(1);
  end

  always_comb begin
    right = (col_inc == cfg.width) ? '0 : right_rd;
    sum = SUM_BITS'(up_rd) + SUM_BITS'(old_value) + SUM_BITS'(window_center)
        + SUM_BITS'(right);
    row_m1 = row_pos - ROW_BITS'(1);
    res = (row_pos != '0) && (row_m1 >= cfg.start_row) && (row_m1 <= cfg.end_row)
        && (col != '0) && (WIDTH_BITS'(col) <= WIDTH_BITS'(cfg.cols));
    clr = (row_pos == '0) && (col == '0);
    s1_next.tag.res = res;
    s1_next.tag.clr = clr;
    s1_next.tag.last = (row_m1 == cfg.end_row) && (WIDTH_BITS'(col) == WIDTH_BITS'(cfg.cols));
    s1_next.tag.row = row_m1;
    s1_next.tag.col = COL_BITS'(col);
    s1_next.sum = sum;
    s1_next.rhs = rhs_rd;
    s1_next.mid = mid_rd;
  end

  always_ff @(posedge clk) begin
    up_rd <= above_mem[rd_col];
    mid_rd <= middle_mem[rd_col];
    right_rd <= middle_mem[rd_col_right];
    rhs_rd <= rhs_mem[rd_col];
    if (accept) begin
      above_mem[col] <= mid_rd;
      middle_mem[col] <= old_value;
      rhs_mem[col] <= rhs_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      window_center <= '0;
      s1_valid <= 1'b0;
    end else begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
      if (accept) begin
        window_center <= mid_rd;
      end
      if (ready) begin
        s1_valid <= accept && (res || clr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      s1 <= s1_next;
    end
  end

endmodule

// ===== src/sps_update_pipe.sv =====
// Multiply, scale, round and saturate stages of the stencil update.
// Two pipeline registers between the window and the result stage. Uses sps_pkg.
module sps_update_pipe
  import sps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [H_BITS-1:0] h_squared,
  input  logic              s1_valid,
  input  stage1_t           s1,
  output logic              s1_ready,
  output logic              s3_valid,
  output stage3_t           s3,
  input  logic              s3_ready
);

  localparam int N_BITS = SUM_BITS + 4;
  localparam int PROD_SHIFT = 30;
  localparam int ROUND_SHIFT = 4;

  typedef struct packed {
    tag_t                         tag;
    logic signed [SUM_BITS-1:0]   sum;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [VALUE_BITS-1:0] mid;
  } stage2_t;

  stage2_t s2;
  logic    s2_valid;
  logic    load2;
  logic    load3;

  logic signed [H_BITS:0]        h_s;
  logic signed [VALUE_BITS-1:0]  rhs_s;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [SUM_BITS-1:0]    sum_s;
  logic signed [PROD_BITS-1:0]   prod_s;
  logic signed [N_BITS-1:0]      n_sum;
  logic signed [N_BITS-1:0]      n_round;
  logic [N_BITS-VALUE_BITS:0]    upper;
  logic signed [VALUE_BITS-1:0]  nv;

  assign load3 = s3_ready;
  assign load2 = !s2_valid || load3;
  assign s1_ready = load2;

  always_comb begin
    h_s = {1'b0, h_squared};
    rhs_s = s1.rhs;
    prod = h_s * rhs_s;
  end

  always_comb begin
    sum_s = s2.sum;
    prod_s = s2.prod;
    n_sum = (N_BITS'(sum_s) <<< 2) + N_BITS'(prod_s >>> PROD_SHIFT);
    n_round = (n_sum + N_BITS'(8)) >>> ROUND_SHIFT;
    upper = n_round[N_BITS-1:VALUE_BITS-1];
    if ((&upper) || !(|upper)) begin
      nv = n_round[VALUE_BITS-1:0];
    end else if (n_round[N_BITS-1]) begin
      nv = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      nv = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (load2) begin
        s2_valid <= s1_valid;
      end
      if (load3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      s2.tag <= s1.tag;
      s2.sum <= s1.sum;
      s2.prod <= prod;
      s2.mid <= s1.mid;
    end
    if (load3) begin
      s3.tag <= s2.tag;
      s3.nv <= nv;
      s3.mid <= s2.mid;
    end
  end

endmodule

// ===== src/sps_result.sv =====
// Change magnitude, running frame maximum and the output register.
// Takes the saturated new value from the update pipe. Uses sps_pkg.
module sps_result
  import sps_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s3_valid,
  input  stage3_t                      s3,
  output logic                         s3_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] new_value,
  output logic [CHANGE_BITS-1:0]       abs_change,
  output logic [CHANGE_BITS-1:0]       max_change,
  output logic [ROW_BITS-1:0]          row_index,
  output logic [COL_BITS-1:0]          column_index,
  output logic                         last
);

  logic [CHANGE_BITS-1:0] running_max;
  logic [CHANGE_BITS-1:0] max_base;
  logic [CHANGE_BITS-1:0] max_new;
  logic [CHANGE_BITS-1:0] ach;
  logic signed [VALUE_BITS:0] diff;
  logic [VALUE_BITS:0]        mag;
  logic out_free;
  logic load;

  assign out_free = !out_valid || !out_stall;
  assign s3_ready = !s3_valid || !s3.tag.res || out_free;
  assign load = s3_valid && s3.tag.res && out_free;

  always_comb begin
    diff = {s3.nv[VALUE_BITS-1], s3.nv} - {s3.mid[VALUE_BITS-1], s3.mid};
    mag = diff[VALUE_BITS] ? (~diff + (VALUE_BITS+1)'(1)) : diff;
    if (|mag[VALUE_BITS:CHANGE_BITS]) begin
      ach = {CHANGE_BITS{1'b1}};
    end else begin
      ach = mag[CHANGE_BITS-1:0];
    end
    max_base = s3.tag.clr ? '0 : running_max;
    max_new = (s3.tag.res && (ach > max_base)) ? ach : max_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      running_max <= '0;
    end else begin
      if (s3_valid && s3_ready) begin
        running_max <= max_new;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      new_value <= s3.nv;
      abs_change <= ach;
      max_change <= max_new;
      row_index <= s3.tag.row;
      column_index <= s3.tag.col;
      last <= s3.tag.last;
    end
  end

endmodule

// ===== src/poisson_stencil_sweep.sv =====
// Top level of the five-point stencil sweep: configuration registers and pipeline.
// Depends on sps_pkg, sps_line_buffer, sps_update_pipe, sps_result and the macros header.
//
// The block takes one beat of the padded old grid and right-hand side per clock while
// in_stall is low, in raster order, from halo row 0, and produces the updated interior
// cell whose stencil the beat completes (the beat is the cell below it). Every cell can
// be taken in consecutive cycles: the sustained rate is one beat per clock while the
// output is not stalled. A result passes four registers on the way: the window register
// after the line stores, the h_squared times rhs multiply, the scale, round and saturate
// step, and the change and running maximum step, which loads the output register.
// Outside reset, the input stalls only when every stage holds an item behind a stalled output.
// The three line stores are 1024 by 32 memories read one beat ahead; they are not
// cleared after reset, so a frame must stream its halo rows before any result.
// Configuration is written by index and applies at once; the user must write it only
// while the block is idle, as the block itself does not enforce this.
`include "poisson_stencil_sweep_macros.svh"

module poisson_stencil_sweep
  import sps_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] old_value,
  input  logic signed [VALUE_BITS-1:0] rhs_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] new_value,
  output logic [CHANGE_BITS-1:0]       abs_change,
  output logic [CHANGE_BITS-1:0]       max_change,
  output logic [ROW_BITS-1:0]          row_index,
  output logic [COL_BITS-1:0]          column_index,
  output logic                         last
);

  logic [COL_BITS-1:0] interior_columns;
  logic [ROW_BITS-1:0] start_row;
  logic [ROW_BITS-1:0] end_row;
  logic [H_BITS-1:0]   h_squared;
  logic [COL_BITS-1:0] interior_columns_next;
  logic [ROW_BITS-1:0] start_row_next;
  logic [ROW_BITS-1:0] end_row_next;
  logic [H_BITS-1:0]   h_squared_next;

  cfg_t    cfg;
  cfg_t    cfg_next;
  logic    s1_valid;
  stage1_t s1;
  logic    s1_ready;
  logic    s3_valid;
  stage3_t s3;
  logic    s3_ready;

  always_comb begin
    interior_columns_next = interior_columns;
    start_row_next = start_row;
    end_row_next = end_row;
    h_squared_next = h_squared;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_INTERIOR_COLUMNS: interior_columns_next = cfg_data[COL_BITS-1:0];
        REG_START_ROW:        start_row_next = cfg_data[ROW_BITS-1:0];
        REG_END_ROW:          end_row_next = cfg_data[ROW_BITS-1:0];
        REG_H_SQUARED:        h_squared_next = cfg_data[H_BITS-1:0];
      endcase
    end
    cfg = make_cfg(interior_columns, start_row, end_row, h_squared);
    cfg_next = make_cfg(interior_columns_next, start_row_next, end_row_next,
                        h_squared_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interior_columns <= COLS_RESET;
      start_row <= START_ROW_RESET;
      end_row <= END_ROW_RESET;
      h_squared <= '0;
    end else begin
      interior_columns <= interior_columns_next;
      start_row <= start_row_next;
      end_row <= end_row_next;
      h_squared <= h_squared_next;
    end
  end

  sps_line_buffer u_line_buffer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_next  (cfg_next),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .old_value (old_value),
    .rhs_value (rhs_value),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_ready  (s1_ready)
  );

  sps_update_pipe u_update_pipe (
    .clk       (clk),
    .rst       (rst),
    .h_squared (cfg.h_squared),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_ready  (s1_ready),
    .s3_valid  (s3_valid),
    .s3        (s3),
    .s3_ready  (s3_ready)
  );

  sps_result u_result (
    .clk          (clk),
    .rst          (rst),
    .s3_valid     (s3_valid),
    .s3           (s3),
    .s3_ready     (s3_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .new_value    (new_value),
    .abs_change   (abs_change),
    .max_change   (max_change),
    .row_index    (row_index),
    .column_index (column_index),
    .last         (last)
  );

  `SPS_ASSERT_IMPLIES(a_max_covers_change, out_valid, max_change >= abs_change)
  `SPS_ASSERT_IMPLIES(a_free_output_takes_input, !out_valid, !in_stall)
  `SPS_ASSERT_IMPLIES(a_result_in_interior, out_valid, (row_index != '0) && (column_index != '0))
  `SPS_ASSERT_HOLDS(a_result_needs_stage, !(s3_valid && s3_ready && s3.tag.res && s3.tag.clr))

endmodule

// ===== dv/sweep_update_checker.sv =====
// Checker for the stencil sweep: predicts every updated cell from the accepted input
// beats and register writes, then compares the output beats field by field.
// Depends on sps_pkg; instantiated by tb_poisson_stencil_sweep.
module sweep_update_checker
  import sps_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] old_value,
  input  logic signed [VALUE_BITS-1:0] rhs_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [VALUE_BITS-1:0] new_value,
  input  logic [CHANGE_BITS-1:0]       abs_change,
  input  logic [CHANGE_BITS-1:0]       max_change,
  input  logic [ROW_BITS-1:0]          row_index,
  input  logic [COL_BITS-1:0]          column_index,
  input  logic                         last,
  output int                           failures,
  output int                           pending
);

  localparam longint VALUE_HI = (longint'(1) << (VALUE_BITS - 1)) - 1;
  localparam longint VALUE_LO = -VALUE_HI - 1;
  localparam longint CHANGE_HI = (longint'(1) << CHANGE_BITS) - 1;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] new_value;
    logic [CHANGE_BITS-1:0]       abs_change;
    logic [CHANGE_BITS-1:0]       max_change;
    logic [ROW_BITS-1:0]          row_index;
    logic [COL_BITS-1:0]          column_index;
    logic                         last;
  } cell_update_t;

  logic [COL_BITS-1:0]    cols_reg;
  logic [ROW_BITS-1:0]    first_reg;
  logic [ROW_BITS-1:0]    last_reg;
  logic [H_BITS-1:0]      h_reg;
  longint                 above_row [MAX_ROW_WIDTH];
  longint                 middle_row [MAX_ROW_WIDTH];
  longint                 rhs_row [MAX_ROW_WIDTH];
  longint                 center_value;
  int                     col_pos;
  int                     row_pos;
  logic [CHANGE_BITS-1:0] frame_max;
  cell_update_t           pending_updates [$];

  initial begin
    failures = 0;
    pending = 0;
  end

  task automatic predict_cell_update(input logic signed [VALUE_BITS-1:0] oldv,
                                     input logic signed [VALUE_BITS-1:0] rhsv);
    int cols, fr, lr, width, c, r;
    longint up, mid, right, left, rh, sum, prod, n, nv, diff;
    cell_update_t u;
    cols = cols_reg;
    if (cols < 1) cols = 1;
    if (cols > MAX_ROW_WIDTH - 2) cols = MAX_ROW_WIDTH - 2;
    fr = first_reg;
    if (fr < 1) fr = 1;
    lr = last_reg;
    if (lr > 65534) lr = 65534;
    width = cols + 2;
    c = col_pos;
    if (c >= width) c = width - 1;
    r = row_pos;
    if (r == 0 && c == 0) frame_max = '0;

    up = above_row[c];
    mid = middle_row[c];
    right = (c + 1 < width) ? middle_row[c + 1] : 0;
    rh = rhs_row[c];
    left = center_value;

    if (r >= 1 && r - 1 >= fr && r - 1 <= lr && c >= 1 && c <= cols) begin
      sum = up + longint'(oldv) + left + right;
      prod = longint'(h_reg) * rh;
      n = sum * 4 + (prod >>> 30);
      nv = (n + 8) >>> 4;
      if (nv > VALUE_HI) nv = VALUE_HI;
      if (nv < VALUE_LO) nv = VALUE_LO;
      diff = nv - mid;
      if (diff < 0) diff = -diff;
      u.abs_change = (diff > CHANGE_HI) ? CHANGE_BITS'(CHANGE_HI) : diff[CHANGE_BITS-1:0];
      if (u.abs_change > frame_max) frame_max = u.abs_change;
      u.new_value = nv[VALUE_BITS-1:0];
      u.max_change = frame_max;
      u.row_index = ROW_BITS'(r - 1);
      u.column_index = COL_BITS'(c);
      u.last = (r - 1 == lr && c == cols);
      pending_updates.push_back(u);
    end

    above_row[c] = mid;
    middle_row[c] = longint'(oldv);
    rhs_row[c] = longint'(rhsv);
    center_value = mid;

    c++;
    if (c >= width) begin
      c = 0;
      r++;
      if (r > lr + 1) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic check_cell_update();
    cell_update_t want;
    int errs;
    errs = 0;
    if (pending_updates.size() == 0) begin
      $display("%0t: output beat with none expected, actual row %0d column %0d",
               $time, row_index, column_index);
      errs = 1;
    end else begin
      want = pending_updates.pop_front();
      if (new_value !== want.new_value) begin
        $display("%0t: new_value expected %0d actual %0d", $time, want.new_value, new_value);
        errs++;
      end
      if (abs_change !== want.abs_change) begin
        $display("%0t: abs_change expected %0d actual %0d", $time, want.abs_change,
                 abs_change);
        errs++;
      end
      if (max_change !== want.max_change) begin
        $display("%0t: max_change expected %0d actual %0d", $time, want.max_change,
                 max_change);
        errs++;
      end
      if (row_index !== want.row_index) begin
        $display("%0t: row_index expected %0d actual %0d", $time, want.row_index, row_index);
        errs++;
      end
      if (column_index !== want.column_index) begin
        $display("%0t: column_index expected %0d actual %0d", $time, want.column_index,
                 column_index);
        errs++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, last);
        errs++;
      end
    end
    if (errs != 0) failures <= failures + errs;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cols_reg = COLS_RESET;
      first_reg = START_ROW_RESET;
      last_reg = END_ROW_RESET;
      h_reg = '0;
      foreach (above_row[i]) begin
        above_row[i] = 0;
        middle_row[i] = 0;
        rhs_row[i] = 0;
      end
      center_value = 0;
      col_pos = 0;
      row_pos = 0;
      frame_max = '0;
      pending_updates.delete();
    end else begin
      // A beat taken at the same edge as a register write still sees the old value.
      if (in_valid && !in_stall) predict_cell_update(old_value, rhs_value);
      if (cfg_write) begin
        case (cfg_index)
          REG_INTERIOR_COLUMNS: cols_reg = cfg_data[COL_BITS-1:0];
          REG_START_ROW: first_reg = cfg_data[ROW_BITS-1:0];
          REG_END_ROW: last_reg = cfg_data[ROW_BITS-1:0];
          REG_H_SQUARED: h_reg = cfg_data[H_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_cell_update();
    end
    pending <= pending_updates.size();
  end

endmodule

// ===== dv/tb_poisson_stencil_sweep.sv =====
// Testbench top for the stencil sweep: clock, reset, register writes, whole-frame
// stimulus with sender and receiver idling, and the verdict.
// Depends on sps_pkg, poisson_stencil_sweep and sweep_update_checker.
module tb_poisson_stencil_sweep
  import sps_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_START = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 12;

  typedef enum int {FILL_RANDOM, FILL_HIGH, FILL_LOW} fill_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write = 1'b0;
  logic [1:0]                   cfg_index = REG_INTERIOR_COLUMNS;
  logic [CFG_BITS-1:0]          cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [VALUE_BITS-1:0] old_value = '0;
  logic signed [VALUE_BITS-1:0] rhs_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [VALUE_BITS-1:0] new_value;
  logic [CHANGE_BITS-1:0]       abs_change;
  logic [CHANGE_BITS-1:0]       max_change;
  logic [ROW_BITS-1:0]          row_index;
  logic [COL_BITS-1:0]          column_index;
  logic                         last;
  int                           failures;
  int                           pending;
  int                           send_idle_pct = 0;
  int                           recv_idle_pct = 0;
  int unsigned                  cycle_count = 0;

  poisson_stencil_sweep dut (.*);

  sweep_update_checker checker_inst (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int frame_beats(input int cols, input int last_raw);
    int c, l;
    c = (cols < 1) ? 1 : (cols > MAX_ROW_WIDTH - 2) ? MAX_ROW_WIDTH - 2 : cols;
    l = (last_raw > 65534) ? 65534 : last_raw;
    return (c + 2) * (l + 2);
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end else if (pick < 55) begin
      return VALUE_BITS'($urandom_range(0, (1 << 21) - 1)) - VALUE_BITS'(1 << 20);
    end
    return VALUE_BITS'($urandom);
  endfunction

  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic send_beat(input logic [VALUE_BITS-1:0] o, input logic [VALUE_BITS-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    old_value <= o;
    rhs_value <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_frame(input int cols, input int first, input int last_raw,
                           input logic [H_BITS-1:0] h, input fill_t fill);
    int beats;
    logic [CFG_BITS-1:0] cfg_word;
    logic [VALUE_BITS-1:0] o, r;
    beats = frame_beats(cols, last_raw);
    drain_results();
    cfg_word = $urandom;
    cfg_word[COL_BITS-1:0] = cols[COL_BITS-1:0];
    write_reg(REG_INTERIOR_COLUMNS, cfg_word);
    cfg_word = $urandom;
    cfg_word[ROW_BITS-1:0] = first[ROW_BITS-1:0];
    write_reg(REG_START_ROW, cfg_word);
    cfg_word = $urandom;
    cfg_word[ROW_BITS-1:0] = last_raw[ROW_BITS-1:0];
    write_reg(REG_END_ROW, cfg_word);
    write_reg(REG_H_SQUARED, h);
    cfg_write <= 1'b0;
    for (int k = 0; k < beats; k++) begin
      case (fill)
        FILL_HIGH: begin
          o = (k % 4 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          r = 32'h7FFF_FFFF;
        end
        FILL_LOW: begin
          o = (k % 4 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
          r = 32'h8000_0000;
        end
        default: begin
          o = random_value();
          r = random_value();
        end
      endcase
      send_beat(o, r);
    end
    in_valid <= 1'b0;
  endtask

  task automatic random_frames(input int target);
    int sent, cols, first, last_raw;
    logic [H_BITS-1:0] h;
    sent = 0;
    while (sent < target) begin
      cols = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 12);
      first = $urandom_range(0, 4);
      last_raw = $urandom_range(0, 8);
      case ($urandom_range(4))
        0: h = '0;
        1: h = '1;
        default: h = $urandom;
      endcase
      run_frame(cols, first, last_raw, h, FILL_RANDOM);
      sent += frame_beats(cols, last_raw);
    end
  endtask

  initial begin : receiver
    int hold_left, own_cycles;
    hold_left = 0;
    own_cycles = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      own_cycles++;
      if (own_cycles == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 15;
    recv_idle_pct = 57;
    run_frame(1, 1, 1, 32'hFFFF_FFFF, FILL_HIGH);
    run_frame(2, 0, 1, 32'hFFFF_FFFF, FILL_LOW);
    run_frame(0, 1, 1, 32'h0000_0000, FILL_RANDOM);
    run_frame(2, 3, 2, 32'h8000_0000, FILL_RANDOM);
    random_frames(470);

    send_idle_pct = 57;
    recv_idle_pct = 15;
    random_frames(470);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_frames(470);
    run_frame(0, 65534, 3, $urandom, FILL_RANDOM);

    drain_results();
    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
